@@ rtl/bfc_pkg.sv @@
// shared types, pattern tables and class codes of the banner classifier
`default_nettype none
package bfc_pkg;

  localparam int FP_COUNT = 14;
  localparam int PAT_MAX  = 11;

  typedef logic [PAT_MAX-1:0][7:0] pat_t;
  typedef logic [3:0]              len_t;
  typedef logic [3:0]              cls_t;
  typedef logic [1:0]              src_t;

  localparam cls_t CLS_UNKNOWN    = 4'd0;
  localparam cls_t CLS_CAMERA     = 4'd1;
  localparam cls_t CLS_DVR        = 4'd2;
  localparam cls_t CLS_NVR        = 4'd3;
  localparam cls_t CLS_ROUTER     = 4'd4;
  localparam cls_t CLS_TV         = 4'd5;
  localparam cls_t CLS_BULB       = 4'd6;
  localparam cls_t CLS_THERMOSTAT = 4'd7;
  localparam cls_t CLS_PRINTER    = 4'd8;
  localparam cls_t CLS_NAS        = 4'd9;
  localparam cls_t CLS_WEB_SERVER = 4'd10;

  localparam src_t SRC_NONE   = 2'd0;
  localparam src_t SRC_BANNER = 2'd1;
  localparam src_t SRC_PORT   = 2'd2;

  // byte 0 holds the last character of a pattern
  localparam pat_t PAT_A [FP_COUNT] = '{
    88'h0000_48696b766973696f6e,
    88'h0000_0000_0000_4461687561,
    88'h0000_0000_00_466f7363616d,
    88'h0000_48696b766973696f6e,
    88'h0000_0000_0000_4461687561,
    88'h0000_0000_54502d4c696e6b,
    88'h0000_0000_00_442d4c696e6b,
    88'h0000_0000_53616d73756e67,
    88'h0000_0000_0000_0000_00_4c47,
    88'h5068696c69707320487565,
    88'h0000_0000_0000_004e657374,
    88'h0000_0000_0000_0000_485020,
    88'h0000_0053796e6f6c6f6779,
    88'h0000_0000_0000_00514e4150
  };

  localparam pat_t PAT_B [FP_COUNT] = '{
    88'h0000_48696b766973696f6e,
    88'h0000_0000_0000_4461687561,
    88'h0000_0000_00_466f7363616d,
    88'h0000_48696b766973696f6e,
    88'h0000_0000_0000_4461687561,
    88'h0000_0000_54502d4c696e6b,
    88'h0000_0000_00_442d4c696e6b,
    88'h0000_0000_53616d73756e67,
    88'h0000_0000_0000_0000_00_4c47,
    88'h0000_0000_5068696c697073,
    88'h0000_0000_0000_004e657374,
    88'h0000_0000_0000_0000_004850,
    88'h0000_0053796e6f6c6f6779,
    88'h0000_0000_0000_00514e4150
  };

  localparam len_t LEN_A [FP_COUNT] = '{
    4'd9, 4'd5, 4'd6, 4'd9, 4'd5, 4'd7, 4'd6, 4'd7, 4'd2, 4'd11, 4'd4, 4'd3, 4'd8, 4'd4
  };

  localparam len_t LEN_B [FP_COUNT] = '{
    4'd9, 4'd5, 4'd6, 4'd9, 4'd5, 4'd7, 4'd6, 4'd7, 4'd2, 4'd7, 4'd4, 4'd2, 4'd8, 4'd4
  };

  localparam cls_t FP_CLS [FP_COUNT] = '{
    CLS_CAMERA, CLS_CAMERA, CLS_CAMERA, CLS_DVR, CLS_NVR, CLS_ROUTER, CLS_ROUTER,
    CLS_TV, CLS_TV, CLS_BULB, CLS_THERMOSTAT, CLS_PRINTER, CLS_NAS, CLS_NAS
  };

  function automatic cls_t port_class(input logic [15:0] port);
    cls_t c;
    case (port)
      16'd23, 16'd2323: c = CLS_ROUTER;
      16'd554:          c = CLS_CAMERA;
      16'd1900:         c = CLS_WEB_SERVER;
      16'd37777:        c = CLS_DVR;
      16'd34567:        c = CLS_CAMERA;
      default:          c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bfc_if.sv @@
// valid/ready channels for banner bytes and classification results
`default_nettype none
interface bfc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  banner_byte;
  logic        byte_valid;
  logic        last_byte;
  logic [15:0] port;
  modport source (output valid, banner_byte, byte_valid, last_byte, port, input ready);
  modport sink   (input valid, banner_byte, byte_valid, last_byte, port, output ready);
endinterface

interface bfc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] device_class;
  logic [1:0] match_source;
  modport source (output valid, device_class, match_source, input ready);
  modport sink   (input valid, device_class, match_source, output ready);
endinterface
`default_nettype wire

@@ rtl/banner_fingerprint_classifier.sv @@
// banner classifier top level: byte window, pattern match, class select, output skid
//
//  channel | dir | beat
//  item    | in  | banner_byte, byte_valid, last_byte, port
//  result  | out | device_class, match_source (one beat per item with last_byte)
//
//  one item per cycle unless stalled; all patterns compare against the shifted window
//  a last item's result is registered in the output or, on a stall, the skid entry
//  a two-entry output buffer keeps item.ready high while one result waits
//  item.ready drops only when both output entries are full
//  synchronous reset clears window, found bits and output valids
`default_nettype none
module banner_fingerprint_classifier
  import bfc_pkg::*;
#(
  parameter int NUM_FINGERPRINTS = 14,
  parameter int WINDOW_BYTES     = 16
) (
  input  wire       clk,
  input  wire       rst,
  bfc_in_if.sink    item,
  bfc_out_if.source result
);

  localparam int ACTIVE = (NUM_FINGERPRINTS > FP_COUNT) ? FP_COUNT : NUM_FINGERPRINTS;

  typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

  window_t           byte_window, byte_window_next;
  logic [ACTIVE-1:0] found_bits, found_bits_next, hit;
  logic              string_ended, string_ended_next;
  logic              saw_character, saw_character_next;

  logic out_valid, skid_valid;
  cls_t out_cls, skid_cls, res_cls;
  src_t out_src, skid_src, res_src;

  logic accept, take_char, out_fire;

  assign item.ready = !skid_valid;
  assign accept     = item.valid && item.ready;
  assign take_char  = item.byte_valid && !string_ended && (item.banner_byte != 8'd0);
  assign out_fire   = out_valid && result.ready;

  assign byte_window_next = {byte_window[WINDOW_BYTES-2:0], item.banner_byte};

  always_comb begin
    logic ma, mb;
    for (int i = 0; i < ACTIVE; i++) begin
      ma = (int'(LEN_A[i]) <= WINDOW_BYTES);
      mb = (int'(LEN_B[i]) <= WINDOW_BYTES);
      for (int k = 0; k < PAT_MAX; k++) begin
        if (k < int'(LEN_A[i]) && byte_window_next[k] != PAT_A[i][k]) ma = 1'b0;
        if (k < int'(LEN_B[i]) && byte_window_next[k] != PAT_B[i][k]) mb = 1'b0;
      end
      hit[i] = ma || mb;
    end
  end

  always_comb begin
    found_bits_next    = found_bits;
    string_ended_next  = string_ended;
    saw_character_next = saw_character;
    if (take_char) begin
      found_bits_next    = found_bits | hit;
      saw_character_next = 1'b1;
    end
    if (item.byte_valid && !string_ended && item.banner_byte == 8'd0) begin
      string_ended_next = 1'b1;
    end
  end

  always_comb begin
    res_cls = CLS_UNKNOWN;
    res_src = SRC_NONE;
    if (saw_character_next) begin
      for (int i = ACTIVE - 1; i >= 0; i--) begin
        if (found_bits_next[i]) begin
          res_cls = FP_CLS[i];
          res_src = SRC_BANNER;
        end
      end
      if (res_src == SRC_NONE && port_class(item.port) != CLS_UNKNOWN) begin
        res_cls = port_class(item.port);
        res_src = SRC_PORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window   <= '0;
      found_bits    <= '0;
      string_ended  <= 1'b0;
      saw_character <= 1'b0;
    end else if (accept) begin
      if (item.last_byte) begin
        byte_window   <= '0;
        found_bits    <= '0;
        string_ended  <= 1'b0;
        saw_character <= 1'b0;
      end else begin
        if (take_char) byte_window <= byte_window_next;
        found_bits    <= found_bits_next;
        string_ended  <= string_ended_next;
        saw_character <= saw_character_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept && item.last_byte && out_valid && !out_fire) begin
        skid_valid <= 1'b1;
        skid_cls   <= res_cls;
        skid_src   <= res_src;
      end else if (out_fire) begin
        skid_valid <= 1'b0;
      end
      if (!out_valid || out_fire) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          out_cls   <= skid_cls;
          out_src   <= skid_src;
        end else if (accept && item.last_byte) begin
          out_valid <= 1'b1;
          out_cls   <= res_cls;
          out_src   <= res_src;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.device_class = out_cls;
  assign result.match_source = out_src;

endmodule
`default_nettype wire

@@ rtl/bfc_checker.sv @@
// port-level checks of the banner classifier and their bind
`default_nettype none
module bfc_checker
  import bfc_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [3:0] device_class,
  input wire [1:0] match_source
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(device_class) && $stable(match_source))
    else $error("stalled result beat changed");

  a_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_source == SRC_NONE |-> device_class == CLS_UNKNOWN)
    else $error("no match but class set");

  a_banner: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_source == SRC_BANNER |->
      device_class != CLS_UNKNOWN && device_class != CLS_WEB_SERVER &&
      device_class <= CLS_NAS)
    else $error("banner class out of range");

  a_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_source == SRC_PORT |->
      device_class == CLS_CAMERA || device_class == CLS_DVR ||
      device_class == CLS_ROUTER || device_class == CLS_WEB_SERVER)
    else $error("port class not in table");

endmodule

bind banner_fingerprint_classifier bfc_checker u_bfc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .device_class (result.device_class),
  .match_source (result.match_source)
);
`default_nettype wire
